>>> src/swfl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfl_pkg
// Shared types and constants of the stop-and-wait frame link.
// ----------------------------------------------------------------------------
package swfl_pkg;

  localparam int unsigned MAX_BODY_DEF = 62;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [7:0]  SEQ_RESET     = 8'd1;
  // The sequence number counts modulo 255, so this value wraps to zero.
  localparam logic [7:0]  SEQ_LAST      = 8'd254;

  typedef enum logic [1:0] {
    OP_BODY = 2'd0,
    OP_ACK  = 2'd1,
    OP_TICK = 2'd2,
    OP_RX   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_FRAME     = 4'd0,
    ST_ACK_OK    = 4'd1,
    ST_BAD_SEQ   = 4'd2,
    ST_BAD_CHECK = 4'd3,
    ST_BOTH_BAD  = 4'd4,
    ST_RX_GOOD   = 4'd5,
    ST_RX_BAD    = 4'd6,
    ST_BUSY      = 4'd7,
    ST_TOO_LONG  = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BODY,
    S_SUM
  } state_t;

endpackage

>>> src/stop_and_wait_frame_link.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stop_and_wait_frame_link
// Stop-and-wait link end: stores an outgoing body, sends it framed with a
// sequence byte and an additive checksum, resends on timeout, checks
// acknowledgements and received frames.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Carries
//   in_       input      in_valid / in_ready  operation, data, last, ack fields
//   out_      output     out_valid/out_ready  out_byte, last_of_run, status
//   cfg_      input      cfg_valid/cfg_ready  timeout_ticks
//
// A request that causes at most one result leaves the block idle; the result sits
// in the output register while the next request may be taken, provided that
// register is free or being drained. A request that sends a frame with n body
// bytes occupies the block while its n + 2 results go out: the body is
// replayed from the frame store at one byte per cycle through its single read
// port. Output stalls hold the replay in place. rst_n is synchronous; the
// frame store is not cleared, since only written entries are ever read.
// ----------------------------------------------------------------------------
module stop_and_wait_frame_link #(
  parameter int unsigned MAX_BODY = swfl_pkg::MAX_BODY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic [7:0]  in_ack_sequence,
  input  logic [7:0]  in_ack_check,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last_of_run,
  output logic [3:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_timeout_ticks
);
  import swfl_pkg::*;

  localparam int unsigned CW = $clog2(MAX_BODY + 1);
  localparam int unsigned AW = $clog2(MAX_BODY);
  localparam logic [CW-1:0] CNT_FULL = CW'(MAX_BODY);

  state_t state_r, state_nxt;

  logic [15:0]   timeout_r;
  logic [CW-1:0] body_count_r, body_count_nxt;
  logic [7:0]    tx_sum_r, tx_sum_nxt;
  logic [7:0]    seq_r, seq_nxt;
  logic [7:0]    sent_sum_r, sent_sum_nxt;
  logic          awaiting_r, awaiting_nxt;
  logic          discard_r, discard_nxt;
  logic [15:0]   timer_r, timer_nxt;
  logic [7:0]    rx_sum_r, rx_sum_nxt;
  logic [AW-1:0] idx_r, idx_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          out_last_r, out_last_nxt;
  status_t       out_status_r, out_status_nxt;

  logic [7:0]    frame_mem [MAX_BODY];
  logic [7:0]    rd_data_r;
  logic          fwd_hit_r;
  logic [7:0]    fwd_data_r;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          mem_we;
  logic [7:0]    body_byte;

  logic          out_free;
  logic          accept;
  logic          emit_start;
  logic          single_req;
  status_t       single_status;
  logic [15:0]   reload;
  logic [7:0]    tx_sum_plus;
  logic [CW-1:0] idx_next_cnt;

  assign out_free     = !out_valid_r || out_ready;
  assign in_ready     = (state_r == S_IDLE) && out_free;
  assign accept       = in_valid && in_ready;
  assign cfg_ready    = 1'b1;
  assign reload       = (timeout_r == 16'd0) ? 16'd1 : timeout_r;
  assign tx_sum_plus  = tx_sum_r + in_data_byte;
  assign idx_next_cnt = CW'(idx_r) + CW'(1);
  assign wr_addr      = body_count_r[AW-1:0];
  // A body byte written in the cycle its entry is read comes from the bypass.
  assign body_byte    = fwd_hit_r ? fwd_data_r : rd_data_r;

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;
  assign out_status      = out_status_r;

  // Decode of the accepted request.
  always_comb begin
    emit_start    = 1'b0;
    single_req    = 1'b0;
    single_status = ST_ACK_OK;
    mem_we        = 1'b0;
    if (accept) begin
      unique case (op_t'(in_operation))
        OP_BODY: begin
          if (awaiting_r) begin
            single_req    = 1'b1;
            single_status = ST_BUSY;
          end else if (!discard_r) begin
            if (body_count_r >= CNT_FULL) begin
              single_req    = 1'b1;
              single_status = ST_TOO_LONG;
            end else begin
              mem_we     = 1'b1;
              emit_start = in_last_byte;
            end
          end
        end
        OP_ACK: begin
          single_req = 1'b1;
          if (awaiting_r) begin
            priority if (in_ack_sequence == seq_r && in_ack_check == sent_sum_r) begin
              single_status = ST_ACK_OK;
            end else if (in_ack_sequence != seq_r && in_ack_check != sent_sum_r) begin
              single_status = ST_BOTH_BAD;
            end else if (in_ack_sequence == seq_r) begin
              single_status = ST_BAD_CHECK;
            end else begin
              single_status = ST_BAD_SEQ;
            end
          end
        end
        OP_TICK: begin
          emit_start = awaiting_r && (timer_r <= 16'd1);
        end
        OP_RX: begin
          single_req    = in_last_byte;
          single_status = (in_data_byte == rx_sum_r) ? ST_RX_GOOD : ST_RX_BAD;
        end
        default: begin
        end
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (emit_start) begin
          state_nxt = S_BODY;
        end
      end
      S_BODY: begin
        if (out_free && idx_next_cnt == body_count_r) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    body_count_nxt = body_count_r;
    tx_sum_nxt     = tx_sum_r;
    seq_nxt        = seq_r;
    sent_sum_nxt   = sent_sum_r;
    awaiting_nxt   = awaiting_r;
    discard_nxt    = discard_r;
    timer_nxt      = timer_r;
    rx_sum_nxt     = rx_sum_r;
    idx_nxt        = '0;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (op_t'(in_operation))
            OP_BODY: begin
              if (!awaiting_r) begin
                if (discard_r) begin
                  if (in_last_byte) begin
                    discard_nxt = 1'b0;
                  end
                end else if (body_count_r >= CNT_FULL) begin
                  body_count_nxt = '0;
                  tx_sum_nxt     = 8'd0;
                  discard_nxt    = !in_last_byte;
                end else begin
                  body_count_nxt = body_count_r + CW'(1);
                  tx_sum_nxt     = tx_sum_plus;
                  if (in_last_byte) begin
                    sent_sum_nxt = tx_sum_plus + seq_r;
                    awaiting_nxt = 1'b1;
                    timer_nxt    = reload;
                  end
                end
              end
            end
            OP_ACK: begin
              if (awaiting_r && single_status == ST_ACK_OK) begin
                awaiting_nxt   = 1'b0;
                timer_nxt      = 16'd0;
                body_count_nxt = '0;
                tx_sum_nxt     = 8'd0;
                seq_nxt        = (seq_r == SEQ_LAST) ? 8'd0 : seq_r + 8'd1;
              end
            end
            OP_TICK: begin
              if (awaiting_r) begin
                timer_nxt = (timer_r > 16'd1) ? timer_r - 16'd1 : reload;
              end
            end
            OP_RX: begin
              rx_sum_nxt = in_last_byte ? 8'd0 : rx_sum_r + in_data_byte;
            end
            default: begin
            end
          endcase

          if (emit_start) begin
            out_valid_nxt  = 1'b1;
            out_byte_nxt   = seq_r;
            out_last_nxt   = 1'b0;
            out_status_nxt = ST_FRAME;
          end else if (single_req) begin
            out_valid_nxt  = 1'b1;
            out_byte_nxt   = 8'd0;
            out_last_nxt   = 1'b1;
            out_status_nxt = single_status;
          end
        end
      end
      S_BODY: begin
        idx_nxt = idx_r;
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = body_byte;
          out_last_nxt   = 1'b0;
          out_status_nxt = ST_FRAME;
          idx_nxt        = (idx_next_cnt == body_count_r) ? '0 : idx_r + AW'(1);
        end
      end
      S_SUM: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = sent_sum_r;
          out_last_nxt   = 1'b1;
          out_status_nxt = ST_FRAME;
        end
      end
      default: begin
      end
    endcase
  end

  // The read address follows the next index, so the registered read data
  // always holds the entry of the current index.
  assign rd_addr = idx_nxt;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[wr_addr] <= in_data_byte;
    end
    rd_data_r  <= frame_mem[rd_addr];
    fwd_hit_r  <= mem_we && (wr_addr == rd_addr);
    fwd_data_r <= in_data_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      timeout_r    <= TIMEOUT_RESET;
      body_count_r <= '0;
      tx_sum_r     <= 8'd0;
      seq_r        <= SEQ_RESET;
      sent_sum_r   <= 8'd0;
      awaiting_r   <= 1'b0;
      discard_r    <= 1'b0;
      timer_r      <= 16'd0;
      rx_sum_r     <= 8'd0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      body_count_r <= body_count_nxt;
      tx_sum_r     <= tx_sum_nxt;
      seq_r        <= seq_nxt;
      sent_sum_r   <= sent_sum_nxt;
      awaiting_r   <= awaiting_nxt;
      discard_r    <= discard_nxt;
      timer_r      <= timer_nxt;
      rx_sum_r     <= rx_sum_nxt;
      idx_r        <= idx_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        timeout_r <= cfg_timeout_ticks;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r   <= out_byte_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

>>> src/swfl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfl_checker
// Port-level checks on the stop-and-wait frame link.
// ----------------------------------------------------------------------------
module swfl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        out_last_of_run,
  input logic [3:0]  out_status
);
  import swfl_pkg::*;

  // A stalled result keeps its contents.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_status)
      && $stable(out_last_of_run))
    else $error("stalled result changed");

  // Status results are single and carry no byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_FRAME |-> out_byte == 8'd0 && out_last_of_run)
    else $error("status result malformed");

  // A request is only taken when the result register can take its result.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid || out_ready)
    else $error("request taken while result register blocked");

  // No status code beyond the defined set.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_TOO_LONG)
    else $error("undefined status code");

  // While a frame is being sent, no new request is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FRAME && !out_last_of_run |-> !in_ready)
    else $error("request taken during frame replay");

endmodule

bind stop_and_wait_frame_link swfl_checker u_swfl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_byte        (out_byte),
  .out_last_of_run (out_last_of_run),
  .out_status      (out_status)
);

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the stop-and-wait frame link. A predictor in
// the testbench tracks the sequence number, the stored body, the wait timer
// and the receive sum. It queues the result bytes that each accepted request
// should cause, and a checker compares every accepted result with the oldest
// queued one. The sender works in bursts and the receiver stalls on its own
// pattern.
// ----------------------------------------------------------------------------
module tb;
  import swfl_pkg::*;

  localparam int BODY_MAX = MAX_BODY_DEF;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    status_t    status;
  } link_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_operation;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic [7:0]  in_ack_sequence;
  logic [7:0]  in_ack_check;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        out_last_of_run;
  logic [3:0]  out_status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_timeout_ticks;

  // Predicted state of the link end.
  logic [7:0]  p_store [BODY_MAX];
  int          p_count    = 0;
  logic [7:0]  p_tx_sum   = 8'd0;
  logic [7:0]  p_seq      = SEQ_RESET;
  logic [7:0]  p_sent_chk = 8'd0;
  logic        p_waiting  = 1'b0;
  logic [15:0] p_timer    = 16'd0;
  logic [7:0]  p_rx_sum   = 8'd0;
  logic        p_dropping = 1'b0;
  logic [15:0] p_timeout  = TIMEOUT_RESET;

  link_result_t link_results_due [$];
  int mismatches    = 0;
  int requests_sent = 0;
  int burst_left    = 0;

  stop_and_wait_frame_link uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .in_ack_sequence  (in_ack_sequence),
    .in_ack_check     (in_ack_check),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_last_of_run  (out_last_of_run),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_timeout_ticks(cfg_timeout_ticks)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("tb: FAIL");
    $finish;
  end

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= 40) $display("tb: mismatch at %0t ns: %s", $time, what);
  endtask

  function automatic logic [15:0] reload_ticks();
    return (p_timeout == 16'd0) ? 16'd1 : p_timeout;
  endfunction

  function automatic void push_result(logic [7:0] data, logic last, status_t status);
    link_result_t r;
    r.data = data;
    r.last = last;
    r.status = status;
    link_results_due.push_back(r);
  endfunction

  // Sequence byte, stored body, checksum; only the checksum closes the run.
  function automatic void queue_frame();
    push_result(p_seq, 1'b0, ST_FRAME);
    for (int i = 0; i < p_count; i++) push_result(p_store[i], 1'b0, ST_FRAME);
    push_result(p_sent_chk, 1'b1, ST_FRAME);
  endfunction

  task automatic advance_link(op_t op, logic [7:0] data, logic last,
                              logic [7:0] aseq, logic [7:0] achk);
    logic seq_ok;
    logic chk_ok;
    case (op)
      OP_BODY: begin
        if (p_waiting) begin
          push_result(8'd0, 1'b1, ST_BUSY);
        end else if (p_dropping) begin
          if (last) p_dropping = 1'b0;
        end else if (p_count >= BODY_MAX) begin
          p_count = 0;
          p_tx_sum = 8'd0;
          p_dropping = !last;
          push_result(8'd0, 1'b1, ST_TOO_LONG);
        end else begin
          p_store[p_count] = data;
          p_count++;
          p_tx_sum = p_tx_sum + data;
          if (last) begin
            p_sent_chk = p_tx_sum + p_seq;
            p_waiting = 1'b1;
            p_timer = reload_ticks();
            queue_frame();
          end
        end
      end
      OP_ACK: begin
        seq_ok = (aseq == p_seq);
        chk_ok = (achk == p_sent_chk);
        if (!p_waiting) begin
          push_result(8'd0, 1'b1, ST_ACK_OK);
        end else if (seq_ok && chk_ok) begin
          p_waiting = 1'b0;
          p_timer = 16'd0;
          p_count = 0;
          p_tx_sum = 8'd0;
          p_seq = (p_seq == SEQ_LAST) ? 8'd0 : p_seq + 8'd1;
          push_result(8'd0, 1'b1, ST_ACK_OK);
        end else if (!seq_ok && !chk_ok) begin
          push_result(8'd0, 1'b1, ST_BOTH_BAD);
        end else begin
          push_result(8'd0, 1'b1, seq_ok ? ST_BAD_CHECK : ST_BAD_SEQ);
        end
      end
      OP_TICK: begin
        if (p_waiting) begin
          if (p_timer > 16'd1) begin
            p_timer = p_timer - 16'd1;
          end else begin
            p_timer = reload_ticks();
            queue_frame();
          end
        end
      end
      default: begin
        if (!last) begin
          p_rx_sum = p_rx_sum + data;
        end else begin
          push_result(8'd0, 1'b1, (data == p_rx_sum) ? ST_RX_GOOD : ST_RX_BAD);
          p_rx_sum = 8'd0;
        end
      end
    endcase
  endtask

  // Returns once the request is accepted; valid stays high so that the next
  // request of a burst can follow at once.
  task automatic send_item(op_t op, logic [7:0] data, logic last,
                           logic [7:0] aseq, logic [7:0] achk);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
    end
    burst_left--;
    in_operation = op;
    in_data_byte = data;
    in_last_byte = last;
    in_ack_sequence = aseq;
    in_ack_check = achk;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
    advance_link(op, data, last, aseq, achk);
  endtask

  task automatic send_body(logic [7:0] data, logic last);
    send_item(OP_BODY, data, last, 8'($urandom), 8'($urandom));
  endtask

  task automatic send_ack(logic [7:0] aseq, logic [7:0] achk);
    send_item(OP_ACK, 8'($urandom), 1'($urandom), aseq, achk);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic send_rx(logic [7:0] data, logic last);
    send_item(OP_RX, data, last, 8'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (link_results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_timeout(logic [15:0] ticks);
    drain();
    @(negedge clk);
    cfg_timeout_ticks = ticks;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    p_timeout = ticks;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Brings the link back to a clean state for a new outgoing body.
  task automatic settle_link();
    if (p_waiting) send_ack(p_seq, p_sent_chk);
    if (p_dropping) send_body(8'($urandom), 1'b1);
  endtask

  task automatic run_exchange();
    int n;
    int k;
    int tick_max;
    logic [7:0] bad_seq;
    logic [7:0] bad_chk;
    settle_link();
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, BODY_MAX) : $urandom_range(1, 8);
    for (k = 1; k <= n; k++) send_body(8'($urandom), k == n);
    repeat ($urandom_range(0, 1)) send_body(8'($urandom), 1'($urandom));
    tick_max = (p_timeout > 16'd8) ? 3 : 2 * int'(p_timeout) + 1;
    repeat ($urandom_range(0, tick_max)) send_tick();
    if ($urandom_range(0, 2) == 0) begin
      bad_seq = p_seq ^ 8'($urandom_range(1, 255));
      bad_chk = p_sent_chk ^ 8'($urandom_range(1, 255));
      case ($urandom_range(0, 2))
        0: send_ack(bad_seq, p_sent_chk);
        1: send_ack(p_seq, bad_chk);
        default: send_ack(bad_seq, bad_chk);
      endcase
    end
    if ($urandom_range(0, 7) != 0) send_ack(p_seq, p_sent_chk);
  endtask

  task automatic run_rx_frame();
    repeat ($urandom_range(0, 7)) send_rx(8'($urandom), 1'b0);
    if ($urandom_range(0, 3) != 0) send_rx(p_rx_sum, 1'b1);
    else send_rx(8'($urandom), 1'b1);
  endtask

  task automatic test_idle_requests();
    send_ack(8'($urandom), 8'($urandom));
    send_tick();
    send_ack(8'hff, 8'hff);
    send_ack(8'h00, 8'h00);
  endtask

  task automatic test_rx_frames();
    send_rx(8'h00, 1'b1);
    send_rx(8'hff, 1'b1);
    send_rx(8'hff, 1'b0);
    send_rx(8'hff, 1'b0);
    send_rx(8'hfe, 1'b1);
    send_rx(8'h12, 1'b0);
    send_rx(8'h00, 1'b1);
  endtask

  // Runs at the reset timeout, so the two ticks must not cause a resend.
  task automatic test_ack_errors();
    send_body(8'hff, 1'b0);
    send_body(8'h00, 1'b1);
    send_body(8'h3c, 1'b1);
    repeat (2) send_tick();
    send_ack(p_seq ^ 8'h80, p_sent_chk);
    send_ack(p_seq, ~p_sent_chk);
    send_ack(~p_seq, ~p_sent_chk);
    send_ack(p_seq, p_sent_chk);
  endtask

  task automatic test_timeout_resend();
    // A zero timeout behaves as one, so every tick resends.
    write_timeout(16'd0);
    send_body(8'h81, 1'b1);
    repeat (2) send_tick();
    send_ack(p_seq, p_sent_chk);
    write_timeout(16'hffff);
    send_body(8'h7e, 1'b1);
    repeat (2) send_tick();
    send_ack(p_seq, p_sent_chk);
  endtask

  task automatic test_long_bodies();
    int k;
    settle_link();
    for (k = 1; k <= BODY_MAX; k++) send_body((k % 2) ? 8'hff : 8'h00, k == BODY_MAX);
    send_ack(p_seq, p_sent_chk);
    // The byte past a full store drops the body; the rest up to last is dropped too.
    for (k = 1; k <= BODY_MAX + 1; k++) send_body(8'($urandom), 1'b0);
    repeat (2) send_body(8'($urandom), 1'b0);
    send_body(8'($urandom), 1'b1);
    send_ack(8'($urandom), 8'($urandom));
    // Here the overflowing byte is itself the last, so nothing is left to drop.
    for (k = 1; k <= BODY_MAX + 1; k++) send_body(8'($urandom), k == BODY_MAX + 1);
    send_body(8'h5a, 1'b0);
    send_body(8'ha5, 1'b1);
    send_ack(p_seq, p_sent_chk);
  endtask

  task automatic test_random_traffic();
    int phase;
    int stop;
    int pick;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_timeout(16'd1);
        1: write_timeout(16'd2);
        2: write_timeout(16'($urandom_range(3, 8)));
        default: write_timeout(16'd1);
      endcase
      stop = requests_sent + 15;
      while (requests_sent < stop) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) run_exchange();
        else if (pick < 8) run_rx_frame();
        else send_item(op_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
                       8'($urandom), 8'($urandom));
      end
    end
  endtask

  // Receiver: switches between always ready, random stalls and a fixed
  // pattern, with an occasional long stall.
  initial begin
    int rx_mode;
    int mode_cycles;
    int stall_left;
    int pattern_step;
    rx_mode = 0;
    mode_cycles = 0;
    stall_left = 0;
    pattern_step = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        case (rx_mode)
          0: out_ready = 1'b1;
          1: out_ready = ($urandom_range(0, 3) != 0);
          default: out_ready = (pattern_step % 5 != 0);
        endcase
        if ($urandom_range(0, 199) == 0) stall_left = $urandom_range(5, 30);
      end
      pattern_step++;
      mode_cycles++;
      if (mode_cycles == 150) begin
        mode_cycles = 0;
        rx_mode = $urandom_range(0, 2);
      end
    end
  end

  always @(posedge clk) begin : check_results
    link_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (link_results_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %02h last %0b status %0d",
                                  out_byte, out_last_of_run, out_status));
      end else begin
        want = link_results_due.pop_front();
        if ({out_byte, out_last_of_run, out_status} !== want)
          report_mismatch($sformatf("got byte %02h last %0b status %0d, want %02h %0b %0d",
                                    out_byte, out_last_of_run, out_status,
                                    want.data, want.last, want.status));
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_TICK;
    in_data_byte = 8'd0;
    in_last_byte = 1'b0;
    in_ack_sequence = 8'd0;
    in_ack_check = 8'd0;
    cfg_valid = 1'b0;
    cfg_timeout_ticks = 16'd0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_idle_requests();
    test_rx_frames();
    test_ack_errors();
    test_timeout_resend();
    test_long_bodies();
    test_random_traffic();
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
